### hw/rtl/sync_length_checksum_deframer_top_macros.svh
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer_top_macros.svh
// Assertion macros used by the deframer top level.
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_CHECKSUM_DEFRAMER_TOP_MACROS_SVH
`define SYNC_LENGTH_CHECKSUM_DEFRAMER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SLCD_ASSERT_NOW(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (expr)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SLCD_ASSERT_NEXT(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (expr)) else $error(msg);

`endif

### hw/rtl/slcd_pkg.sv
// ----------------------------------------------------------------------------
// slcd_pkg
// Types and constants of the sync/length/checksum deframer.
// ----------------------------------------------------------------------------
package slcd_pkg;

    localparam logic [7:0] SYNC_BYTE     = 8'hAA;
    localparam logic [7:0] SYNC_HIGH_LEN = 8'h00;

    // Decoder phase
    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_SYNC0 = 3'd1,
        PH_LEN   = 3'd2,
        PH_DATA  = 3'd3,
        PH_CHECK = 3'd4
    } t_phase;

    // Result kind
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_ACCEPT  = 2'd1,
        KIND_REJECT  = 2'd2
    } t_kind;

    // One result beat plus its valid flag
    typedef struct packed {
        logic       valid;
        t_kind      kind;
        logic [7:0] data;
        logic [7:0] index;
        logic [7:0] frame_length;
    } t_result;

endpackage

### hw/rtl/slcd_decoder.sv
// ----------------------------------------------------------------------------
// slcd_decoder
// Frame state machine: sync hunt, length capture, payload indexing and
// running checksum. Produces at most one result per processed byte.
// ----------------------------------------------------------------------------
module slcd_decoder
    import slcd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    output t_result    o_res
);

    t_phase     r_phase, n_phase;
    logic [7:0] r_sum,   n_sum;
    logic [7:0] r_rem,   n_rem;
    logic [7:0] r_pos,   n_pos;
    logic [7:0] r_len,   n_len;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_sum   <= '0;
            r_rem   <= '0;
            r_pos   <= '0;
            r_len   <= '0;
        end else begin
            r_phase <= n_phase;
            r_sum   <= n_sum;
            r_rem   <= n_rem;
            r_pos   <= n_pos;
            r_len   <= n_len;
        end
    end

    // Next state
    always_comb begin
        n_phase = r_phase;
        n_sum   = r_sum;
        n_rem   = r_rem;
        n_pos   = r_pos;
        n_len   = r_len;
        if (i_fire) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_byte == SYNC_BYTE) n_phase = PH_SYNC0;
                end
                PH_SYNC0: begin
                    // a bad high length byte is not rechecked as sync
                    n_phase = (i_byte == SYNC_HIGH_LEN) ? PH_LEN : PH_HUNT;
                end
                PH_LEN: begin
                    n_len   = i_byte;
                    n_sum   = i_byte;
                    n_rem   = i_byte;
                    n_pos   = '0;
                    // empty frame goes straight to the checksum
                    n_phase = (i_byte == 8'd0) ? PH_CHECK : PH_DATA;
                end
                PH_DATA: begin
                    n_sum = r_sum + i_byte;
                    n_pos = r_pos + 8'd1;
                    n_rem = r_rem - 8'd1;
                    if (n_rem == 8'd0) n_phase = PH_CHECK;
                end
                PH_CHECK: begin
                    n_phase = PH_HUNT;
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    // Result for the byte being processed
    always_comb begin
        o_res              = '0;
        o_res.kind         = KIND_PAYLOAD;
        o_res.frame_length = r_len;
        unique case (r_phase)
            PH_DATA: begin
                o_res.valid = i_fire;
                o_res.data  = i_byte;
                o_res.index = r_pos;
            end
            PH_CHECK: begin
                o_res.valid = i_fire;
                o_res.kind  = (8'(r_sum + i_byte) == 8'd0) ? KIND_ACCEPT : KIND_REJECT;
            end
            default: begin
                o_res.valid = 1'b0;
            end
        endcase
    end

endmodule

### hw/rtl/slcd_out_reg.sv
// ----------------------------------------------------------------------------
// slcd_out_reg
// Result register in front of the output channel. Loads on i_load; o_free
// shows that the held beat is taken or the slot is empty.
// ----------------------------------------------------------------------------
module slcd_out_reg
    import slcd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_ready,
    output logic    o_free,
    output t_result o_res
);

    logic       r_valid;
    t_result    r_res;

    // slot can take a new result this cycle
    assign o_free = !r_valid || i_ready;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_res.valid;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_load && i_res.valid) begin
            r_res <= i_res;
        end
    end

    always_comb begin
        o_res       = r_res;
        o_res.valid = r_valid;
    end

endmodule

### hw/rtl/sync_length_checksum_deframer_top.sv
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer_top
// Byte-stream deframer: sync 0xAA, high length 0x00, length, payload,
// 8-bit additive checksum.
//
// Input channel: one received byte per beat on i_rx_byte (i_valid/o_ready).
// Output channel: o_kind, o_data, o_index, o_frame_length (o_valid/i_ready).
// A payload byte gives a payload beat with its index; the checksum byte
// gives an accept or reject beat; sync, high length and length bytes give
// no beat. A byte goes through an input register, then the decoder and
// checksum adder, then the result register, which offers the result.
// One byte per cycle is sustained while the receiver takes every beat;
// the rate is set by the single decoder pass and the 8-bit adder.
// Reset (synchronous, active low) empties both registers and puts the
// decoder back to the sync hunt with sum, count and length cleared.
// When the receiver stalls, the result register holds its beat; one more
// byte waits in the input register, then o_ready drops until the output
// moves again.
// ----------------------------------------------------------------------------
`include "sync_length_checksum_deframer_top_macros.svh"

module sync_length_checksum_deframer_top
    import slcd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_kind,
    output logic [7:0] o_data,
    output logic [7:0] o_index,
    output logic [7:0] o_frame_length
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       w_fire;
    logic       w_free;
    t_result    w_dec_res;
    t_result    w_out_res;

    // Process the held byte when the result slot can take its outcome
    assign w_fire  = r_in_valid && w_free;
    assign o_ready = !r_in_valid || w_fire;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    slcd_decoder u_decoder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_byte  (r_in_byte),
        .o_res   (w_dec_res)
    );

    slcd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_fire),
        .i_res   (w_dec_res),
        .i_ready (i_ready),
        .o_free  (w_free),
        .o_res   (w_out_res)
    );

    assign o_valid        = w_out_res.valid;
    assign o_kind         = w_out_res.kind;
    assign o_data         = w_out_res.data;
    assign o_index        = w_out_res.index;
    assign o_frame_length = w_out_res.frame_length;

    // Checks
    `SLCD_ASSERT_NOW(a_payload_index_in_frame, o_valid && o_kind == KIND_PAYLOAD, o_index < o_frame_length, "payload index beyond announced length")
    `SLCD_ASSERT_NOW(a_verdict_zero_fields, o_valid && o_kind != KIND_PAYLOAD, o_data == 8'd0 && o_index == 8'd0, "verdict beat carries nonzero data or index")
    `SLCD_ASSERT_NOW(a_stall_only_when_full, !o_ready, r_in_valid && o_valid && !i_ready, "input stalled without a held byte and a stalled result")
    `SLCD_ASSERT_NEXT(a_held_byte_kept, r_in_valid && !w_fire, r_in_valid, "held input byte lost without processing")

endmodule
